// ===== sv/modular_exponentiation_cipher_macros.svh =====
// Assertion macros for the modular exponentiation block.
// Used by the checker only; no dependencies.
`ifndef MODULAR_EXPONENTIATION_CIPHER_MACROS_SVH
`define MODULAR_EXPONENTIATION_CIPHER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MEC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("modexp check failed");

// Check a property on every clock edge, reset included.
`define MEC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("modexp reset check failed");

`endif

// ===== sv/mec_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mec_pkg;

    localparam int FIELD_W   = 16;
    localparam int CFG_IDX_W = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b1;

    localparam logic [FIELD_W-1:0] EXPONENT_RESET = 16'd3;
    localparam logic [FIELD_W-1:0] MODULUS_RESET  = 16'd2773;

    typedef struct packed {
        logic [FIELD_W-1:0] value;
        logic               last;
    } t_in_beat;

    typedef struct packed {
        logic [FIELD_W-1:0] result;
        logic               last_out;
    } t_out_beat;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture an input beat and the configuration
        logic step;      // one multiplier bit in both lanes
        logic reduce;    // lane A multiplies by one (initial reduction)
        logic fin;       // last bit of a pass: commit the products
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // output register empty or being taken
    } t_dp_status;

endpackage

`default_nettype wire

// ===== sv/mec_ctrl.sv =====
// Sequencer for the modular exponentiation block.
// Depends on mec_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module mec_ctrl #(
    parameter int WIDTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire mec_pkg::t_dp_status i_status,
    output mec_pkg::t_dp_cmd         o_cmd
);
    import mec_pkg::*;

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REDUCE = 2'd1;
    localparam logic [1:0] S_EXP    = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_step,  n_step;
    logic [CW-1:0] r_round, n_round;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_round    = r_round;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.step   = 1'b1;
                o_cmd.reduce = 1'b1;
                if (r_step == LAST) begin
                    o_cmd.fin = 1'b1;
                    n_step    = '0;
                    n_round   = '0;
                    n_state   = S_EXP;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_EXP: begin
                o_cmd.step = 1'b1;
                if (r_step == LAST) begin
                    o_cmd.fin = 1'b1;
                    n_step    = '0;
                    if (r_round == LAST) begin
                        n_state = S_DONE;
                    end else begin
                        n_round = r_round + 1'b1;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_round <= n_round;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mec_dp.sv =====
// Datapath: two bit-serial modular multipliers, operand registers and
// the output register. Depends on mec_pkg for beat and command types.
`timescale 1ns / 1ps
`default_nettype none

module mec_dp #(
    parameter int WIDTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mec_pkg::t_dp_cmd      i_cmd,
    input  wire mec_pkg::t_in_beat     i_in_beat,
    input  wire logic [mec_pkg::FIELD_W-1:0] i_exponent,
    input  wire logic [mec_pkg::FIELD_W-1:0] i_modulus,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output mec_pkg::t_out_beat         o_out_beat,
    output mec_pkg::t_dp_status        o_status
);
    import mec_pkg::*;

    localparam logic [WIDTH-1:0] ONE = {{(WIDTH-1){1'b0}}, 1'b1};
    localparam logic [WIDTH-1:0] TWO = WIDTH'(2);

    logic [WIDTH-1:0] r_exp, r_mod, r_acc, r_sq, r_pa, r_pb, r_b;
    logic             r_last;
    logic             r_out_valid;
    t_out_beat        r_out_beat;

    logic [WIDTH-1:0] mult_a;
    logic [WIDTH-1:0] nxt_pa, nxt_pb;

    // r = (2r + bit*a) mod m, with r and a below m
    function automatic logic [WIDTH-1:0] mod_step(
        input logic [WIDTH-1:0] r,
        input logic [WIDTH-1:0] a,
        input logic             b,
        input logic [WIDTH-1:0] m
    );
        logic [WIDTH:0] d;
        logic [WIDTH:0] s;
        d = {r, 1'b0};
        if (d >= {1'b0, m}) begin
            d = d - {1'b0, m};
        end
        s = {1'b0, d[WIDTH-1:0]} + (b ? {1'b0, a} : '0);
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[WIDTH-1:0];
    endfunction

    assign mult_a = i_cmd.reduce ? ONE : r_acc;
    assign nxt_pa = mod_step(r_pa, mult_a, r_b[WIDTH-1], r_mod);
    assign nxt_pb = mod_step(r_pb, r_sq,   r_b[WIDTH-1], r_mod);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_exp  <= WIDTH'(i_exponent);
            r_mod  <= WIDTH'(i_modulus);
            r_b    <= WIDTH'(i_in_beat.value);
            r_last <= i_in_beat.last;
            r_acc  <= ONE;
            r_sq   <= '0;
            r_pa   <= '0;
            r_pb   <= '0;
        end else if (i_cmd.step) begin
            if (i_cmd.fin) begin
                r_pa <= '0;
                r_pb <= '0;
                if (i_cmd.reduce) begin
                    r_sq <= nxt_pa;
                    r_b  <= nxt_pa;
                end else begin
                    if (r_exp[0]) begin
                        r_acc <= nxt_pa;
                    end
                    r_sq  <= nxt_pb;
                    r_b   <= nxt_pb;
                    r_exp <= r_exp >> 1;
                end
            end else begin
                r_pa <= nxt_pa;
                r_pb <= nxt_pb;
                r_b  <= r_b << 1;
            end
        end
    end

    // output register: modulus below two gives zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_beat.result   <= (r_mod < TWO) ? '0 : FIELD_W'(r_acc);
            r_out_beat.last_out <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_beat        = r_out_beat;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

// ===== sv/modular_exponentiation_cipher.sv =====
// Modular exponentiation block: value^exponent mod modulus, one item at a
// time, right-to-left square-and-multiply on WIDTH-bit operands. An item
// passes through an accept step, the initial reduction of the value, WIDTH
// passes over the exponent bits, and a hand-off of the result to the output
// register once that register is free. The run time is set by the pair of
// bit-serial modular multipliers, which retire one multiplier bit per cycle;
// squaring and the conditional multiply run side by side in one pass. The
// output register lets the next item start while a result waits. A modulus
// below two gives 0.
// Depends on mec_pkg, mec_ctrl and mec_dp.
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation_cipher #(
    parameter int WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire mec_pkg::t_in_beat             i_in_beat,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output mec_pkg::t_out_beat                 o_out_beat,
    input  wire logic                          i_cfg_we,
    input  wire logic [mec_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mec_pkg::FIELD_W-1:0]   i_cfg_data
);
    import mec_pkg::*;

    logic [FIELD_W-1:0] r_exponent;
    logic [FIELD_W-1:0] r_modulus;
    t_dp_cmd            cmd;
    t_dp_status         status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= EXPONENT_RESET;
            r_modulus  <= MODULUS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXPONENT: r_exponent <= i_cfg_data;
                CFG_MODULUS:  r_modulus  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mec_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mec_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_beat   (i_in_beat),
        .i_exponent  (r_exponent),
        .i_modulus   (r_modulus),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .o_status    (status)
    );

endmodule

`default_nettype wire

// ===== sv/mec_checker.sv =====
// Port-level checks for the modular exponentiation block, bound to the
// top level. Depends on mec_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "modular_exponentiation_cipher_macros.svh"

module mec_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire mec_pkg::t_out_beat            o_out_beat
);
    import mec_pkg::*;

    logic in_beat_taken;
    logic out_stalled;

    assign in_beat_taken = i_in_valid && o_in_ready;
    assign out_stalled   = o_out_valid && !i_out_ready;

    // a stalled result holds
    `MEC_ASSERT(a_out_hold, i_clk, i_rst_n, out_stalled |=> (o_out_valid && $stable(o_out_beat)))
    // the block is busy once it has taken a beat
    `MEC_ASSERT(a_busy_after_take, i_clk, i_rst_n, in_beat_taken |=> !o_in_ready)
    // with the output empty, no result can follow a beat in the very next cycle
    `MEC_ASSERT(a_no_instant_result, i_clk, i_rst_n, (in_beat_taken && !o_out_valid) |=> !o_out_valid)
    // reset empties the output and opens the input
    `MEC_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> (!o_out_valid && o_in_ready))

endmodule

bind modular_exponentiation_cipher mec_checker u_mec_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for modular_exponentiation_cipher: directed edge cases, then
// random keys and values under random gaps and stalls, and a run with neither.
// Results are predicted bit-exact. Depends on mec_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
    import mec_pkg::*;

    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int DRAIN_CYCLES = 300;   // above one item's pass through the block
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS = 105;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_beat             i_in_beat   = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [FIELD_W-1:0]   i_cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    t_out_beat            o_out_beat;

    // shadow of the configuration registers
    logic [FIELD_W-1:0] cfg_exponent = EXPONENT_RESET;
    logic [FIELD_W-1:0] cfg_modulus  = MODULUS_RESET;

    t_out_beat pending_results[$];
    int        error_count = 0;
    int        cycle_count = 0;
    int        stall_left  = 0;
    bit        idle_on     = 1'b1;

    modular_exponentiation_cipher #(
        .WIDTH (FIELD_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // right-to-left square-and-multiply at double width
    function automatic logic [FIELD_W-1:0] modexp_predict(input logic [FIELD_W-1:0] base,
                                                         input logic [FIELD_W-1:0] exp_bits,
                                                         input logic [FIELD_W-1:0] modulus);
        logic [2*FIELD_W-1:0] acc;
        logic [2*FIELD_W-1:0] sq;
        logic [2*FIELD_W-1:0] m;
        if (modulus < 2) begin
            return '0;
        end
        m   = {{FIELD_W{1'b0}}, modulus};
        acc = 1 % m;
        sq  = {{FIELD_W{1'b0}}, base} % m;
        for (int b = 0; b < FIELD_W; b++) begin
            if (exp_bits[b]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
        end
        return acc[FIELD_W-1:0];
    endfunction

    // mostly short, a few long
    function automatic int pick_idle_len();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 4);
        end else begin
            return $urandom_range(20, 60);
        end
    endfunction

    function automatic logic [FIELD_W-1:0] pick_value(input logic [FIELD_W-1:0] modulus);
        int r;
        int m;
        m = int'(modulus);
        r = $urandom_range(0, 9);
        if (r < 5 || m == 0) begin
            return 16'($urandom_range(0, 65535));
        end else if (r < 8) begin
            return 16'($urandom_range(0, m - 1));
        end else if (r == 8) begin
            case ($urandom_range(0, 4))
                0: return '0;
                1: return 16'd1;
                2: return modulus - 16'd1;
                3: return modulus;
                default: return '1;
            endcase
        end else begin
            return 16'($urandom_range(m, 65535));
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [FIELD_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        if (index == CFG_EXPONENT) begin
            cfg_exponent = data;
        end else begin
            cfg_modulus = data;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_key(input logic [FIELD_W-1:0] exponent, input logic [FIELD_W-1:0] modulus);
        write_reg(CFG_EXPONENT, exponent);
        write_reg(CFG_MODULUS, modulus);
    endtask

    // hold the beat until the block takes it, then record what it must return
    task automatic send_value(input logic [FIELD_W-1:0] val, input logic last);
        int        gap;
        t_out_beat expected;
        gap = pick_idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= '{value: val, last: last};
        do @(posedge i_clk); while (!o_in_ready);
        expected.result   = modexp_predict(val, cfg_exponent, cfg_modulus);
        expected.last_out = last;
        pending_results   = {pending_results, expected};
    endtask

    task automatic wait_drain(input int settle);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic test_reset_values();
        send_value(16'd0, 1'b0);
        send_value(16'd1, 1'b1);
        send_value(16'd2, 1'b0);
        send_value(16'd2772, 1'b0);
        send_value(16'd2773, 1'b1);
        send_value(16'd2774, 1'b0);
        send_value(16'hFFFF, 1'b1);
        wait_drain(4);
    endtask

    task automatic test_exponent_edges();
        set_key(16'd0, 16'd2773);
        send_value(16'd0, 1'b0);
        send_value(16'hFFFF, 1'b1);
        wait_drain(1);
        set_key(16'd1, 16'd50021);
        send_value(16'd60000, 1'b0);
        wait_drain(1);
        set_key(16'hFFFF, 16'hFFFF);
        send_value(16'hFFFE, 1'b0);
        send_value(16'd2, 1'b1);
        wait_drain(4);
    endtask

    // below-range moduli give zero; value at or above the modulus is reduced first
    task automatic test_modulus_edges();
        set_key(16'd5, 16'd0);
        send_value(16'd12345, 1'b0);
        send_value(16'hFFFF, 1'b1);
        wait_drain(1);
        write_reg(CFG_MODULUS, 16'd1);
        send_value(16'hFFFF, 1'b0);
        wait_drain(1);
        write_reg(CFG_MODULUS, 16'd2);
        send_value(16'd1, 1'b0);
        send_value(16'hFFFF, 1'b1);
        wait_drain(1);
        write_reg(CFG_MODULUS, 16'hFFFF);
        send_value(16'hFFFF, 1'b0);
        send_value(16'd40000, 1'b1);
        wait_drain(4);
    endtask

    // encrypt a short message, then decrypt the predicted ciphertext
    task automatic test_textbook_key();
        logic [FIELD_W-1:0] cipher[20];
        set_key(16'd17, 16'd3233);
        for (int k = 0; k < 20; k++) begin
            cipher[k] = modexp_predict(16'(k * 151 % 3233), 16'd17, 16'd3233);
            send_value(16'(k * 151 % 3233), k == 19);
        end
        wait_drain(4);
        write_reg(CFG_EXPONENT, 16'd2753);
        for (int k = 0; k < 20; k++) begin
            send_value(cipher[k], k == 19);
        end
        wait_drain(4);
    endtask

    task automatic test_random_keys();
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
        int                 r;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            r = $urandom_range(0, 9);
            exponent = (r == 0) ? 16'hFFFF : (r == 1) ? 16'($urandom_range(0, 3))
                                                      : 16'($urandom_range(0, 65535));
            r = $urandom_range(0, 19);
            modulus = (r == 0) ? 16'($urandom_range(0, 1)) : (r < 3) ? 16'hFFFF
                    : (r < 5) ? 16'($urandom_range(2, 3)) : 16'($urandom_range(2, 65535));
            set_key(exponent, modulus);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_value(pick_value(modulus), $urandom_range(0, 4) == 0);
            end
            wait_drain(4);
        end
    endtask

    // no gaps and no stalls: beats follow one another as fast as the block allows
    task automatic test_back_to_back();
        idle_on = 1'b0;
        set_key(16'($urandom_range(0, 65535)), 16'($urandom_range(2, 65535)));
        for (int k = 0; k < 60; k++) begin
            send_value(pick_value(cfg_modulus), 1'($urandom_range(0, 1)));
        end
        wait_drain(4);
        idle_on = 1'b1;
    endtask

    // drive the output ready and check every beat taken
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected beat, expected none, actual result %0d last_out %0b",
                             $time, o_out_beat.result, o_out_beat.last_out);
                end else begin
                    if (o_out_beat.result !== pending_results[0].result) begin
                        error_count++;
                        $display("%0t: result mismatch, expected %0d actual %0d", $time,
                                 pending_results[0].result, o_out_beat.result);
                    end
                    if (o_out_beat.last_out !== pending_results[0].last_out) begin
                        error_count++;
                        $display("%0t: last_out mismatch, expected %0b actual %0b", $time,
                                 pending_results[0].last_out, o_out_beat.last_out);
                    end
                    void'(pending_results.pop_front());
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < 30) begin
                stall_left = pick_idle_len();
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_exponent_edges();
        test_modulus_edges();
        test_textbook_key();
        test_random_keys();
        test_back_to_back();
        wait_drain(DRAIN_CYCLES);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== modular_exponentiation_cipher.f =====
+incdir+sv
sv/mec_pkg.sv
sv/mec_ctrl.sv
sv/mec_dp.sv
sv/modular_exponentiation_cipher.sv
sv/mec_checker.sv
verif/tb.sv
